@@ rtl/dcm_pkg.sv @@
// Shared types and constants for the DC motor Euler model.
// Holds the controller states, multiplier operation codes, the command and
// status structs between controller and datapath, and register indexes.
package dcm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int SUBSTEP_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_COEFF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_INERTIA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEP_TIME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEPS          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_RADIAN = 3'd5;

    localparam logic [31:0]          INVERSE_INERTIA_RST   = 32'd65536;
    localparam logic [31:0]          SUBSTEP_TIME_RST      = 32'd4294967;
    localparam logic [31:0]          COUNTS_PER_RADIAN_RST = 32'd65536;
    localparam logic [SUBSTEP_W-1:0] SUBSTEPS_RST          = 11'd1;
    localparam logic [SUBSTEP_W-1:0] MAX_SUBSTEPS          = 11'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_ADDV,
        ST_ADDP,
        ST_CLAMP
    } state_t;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_CMB
    } mul_phase_t;

    typedef enum logic [2:0] {
        MUL_FR,
        MUL_ACC,
        MUL_DV,
        MUL_DP,
        MUL_CNT
    } mul_op_t;

    typedef struct packed {
        logic [31:0] torque_gain;
        logic [31:0] friction_coeff;
        logic [31:0] inverse_inertia;
        logic [31:0] substep_time;
        logic [31:0] counts_per_radian;
    } coef_t;

    typedef struct packed {
        logic    load;
        logic    mul_lo;
        logic    mul_hi;
        logic    mul_cmb;
        mul_op_t op;
        logic    sub;
        logic    addv;
        logic    addp;
        logic    clamp;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

@@ rtl/dc_motor_euler_model.sv @@
// Top level of the DC motor Euler model: configuration registers and the
// controller and datapath instances. Depends on dcm_pkg, dcm_ctrl, dcm_dpath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid, in_stall  | current_command
//  output   | out_valid, out_stall| encoder_position, position_saturated
//  config   | cfg_we              | cfg_index, cfg_data
//
// An item runs N substeps, N being the substep count clamped to 1024: each
// substep makes four 64 by 32 products on one shared pair of 32-bit
// multipliers plus three saturating add or subtract steps.
// Reset clears velocity, position, the controller and the output valid flag;
// no clearing pass is needed. A new item is taken while a result still waits
// in the output register; a stalled output holds the block before its next
// result is written.
module dc_motor_euler_model (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [15:0]             current_command,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             encoder_position,
    output logic                           position_saturated,
    input  logic                           cfg_we,
    input  logic [dcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    dcm_pkg::coef_t                  coef_reg;
    logic [dcm_pkg::SUBSTEP_W-1:0]   substeps_reg;
    dcm_pkg::dp_cmd_t                cmd;
    dcm_pkg::dp_stat_t               stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.torque_gain       <= '0;
            coef_reg.friction_coeff    <= '0;
            coef_reg.inverse_inertia   <= dcm_pkg::INVERSE_INERTIA_RST;
            coef_reg.substep_time      <= dcm_pkg::SUBSTEP_TIME_RST;
            coef_reg.counts_per_radian <= dcm_pkg::COUNTS_PER_RADIAN_RST;
            substeps_reg               <= dcm_pkg::SUBSTEPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcm_pkg::CFG_TORQUE_GAIN:       coef_reg.torque_gain       <= cfg_data;
                dcm_pkg::CFG_FRICTION_COEFF:    coef_reg.friction_coeff    <= cfg_data;
                dcm_pkg::CFG_INVERSE_INERTIA:   coef_reg.inverse_inertia   <= cfg_data;
                dcm_pkg::CFG_SUBSTEP_TIME:      coef_reg.substep_time      <= cfg_data;
                dcm_pkg::CFG_SUBSTEPS:
                    substeps_reg <= cfg_data[dcm_pkg::SUBSTEP_W-1:0];
                dcm_pkg::CFG_COUNTS_PER_RADIAN: coef_reg.counts_per_radian <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .substeps (substeps_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    dcm_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .current_command    (current_command),
        .coef               (coef_reg),
        .cmd                (cmd),
        .stat               (stat),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .encoder_position   (encoder_position),
        .position_saturated (position_saturated)
    );

`ifndef SYNTHESIS
    // A result is written only when the output register is free or draining.
    a_clamp_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clamp |-> !(out_valid && out_stall))
        else $error("result written over a waiting result");

    // One item at a time: after an accepted item the input side is stalled.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while one is in work");

    // A written result is presented in the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clamp |=> out_valid)
        else $error("written result not presented");

    // The multiplier phases only run while the input side is stalled.
    a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_lo || cmd.mul_hi || cmd.mul_cmb) |-> in_stall)
        else $error("multiplier active while idle");
`endif

endmodule

@@ rtl/dcm_ctrl.sv @@
// Controller state machine of the DC motor Euler model.
// Sequences the substep operations and the final scaling; uses dcm_pkg.
module dcm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dcm_pkg::SUBSTEP_W-1:0]  substeps,
    input  dcm_pkg::dp_stat_t              stat,
    output dcm_pkg::dp_cmd_t               cmd
);

    dcm_pkg::state_t                 state_reg, state_next;
    dcm_pkg::mul_phase_t             phase_reg, phase_next;
    dcm_pkg::mul_op_t                op_reg, op_next;
    logic [dcm_pkg::SUBSTEP_W-1:0]   left_reg, left_next;
    logic [dcm_pkg::SUBSTEP_W-1:0]   n_sat;

    assign n_sat = (substeps > dcm_pkg::MAX_SUBSTEPS) ? dcm_pkg::MAX_SUBSTEPS : substeps;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcm_pkg::ST_IDLE;
            phase_reg <= dcm_pkg::PH_LO;
            op_reg    <= dcm_pkg::MUL_FR;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
            left_reg  <= left_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        op_next    = op_reg;
        left_next  = left_reg;
        case (state_reg)
            dcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dcm_pkg::ST_MUL;
                    phase_next = dcm_pkg::PH_LO;
                    left_next  = n_sat;
                    op_next    = (n_sat == '0) ? dcm_pkg::MUL_CNT : dcm_pkg::MUL_FR;
                end
            end
            dcm_pkg::ST_MUL:
            begin
                case (phase_reg)
                    dcm_pkg::PH_LO:
                    begin
                        phase_next = dcm_pkg::PH_HI;
                    end
                    dcm_pkg::PH_HI:
                    begin
                        phase_next = dcm_pkg::PH_CMB;
                    end
                    dcm_pkg::PH_CMB:
                    begin
                        phase_next = dcm_pkg::PH_LO;
                        case (op_reg)
                            dcm_pkg::MUL_FR:  state_next = dcm_pkg::ST_SUB;
                            dcm_pkg::MUL_ACC: op_next    = dcm_pkg::MUL_DV;
                            dcm_pkg::MUL_DV:  state_next = dcm_pkg::ST_ADDV;
                            dcm_pkg::MUL_DP:  state_next = dcm_pkg::ST_ADDP;
                            default:          state_next = dcm_pkg::ST_CLAMP;
                        endcase
                    end
                    default:
                    begin
                        phase_next = dcm_pkg::PH_LO;
                    end
                endcase
            end
            dcm_pkg::ST_SUB:
            begin
                state_next = dcm_pkg::ST_MUL;
                op_next    = dcm_pkg::MUL_ACC;
            end
            dcm_pkg::ST_ADDV:
            begin
                state_next = dcm_pkg::ST_MUL;
                op_next    = dcm_pkg::MUL_DP;
            end
            dcm_pkg::ST_ADDP:
            begin
                // The last substep hands over to the encoder scaling.
                state_next = dcm_pkg::ST_MUL;
                left_next  = left_reg - 1'b1;
                op_next    = (left_reg == 1) ? dcm_pkg::MUL_CNT : dcm_pkg::MUL_FR;
            end
            dcm_pkg::ST_CLAMP:
            begin
                if (!stat.out_busy)
                begin
                    state_next = dcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.op      = op_reg;
        cmd.load    = (state_reg == dcm_pkg::ST_IDLE) && in_valid;
        cmd.mul_lo  = (state_reg == dcm_pkg::ST_MUL) && (phase_reg == dcm_pkg::PH_LO);
        cmd.mul_hi  = (state_reg == dcm_pkg::ST_MUL) && (phase_reg == dcm_pkg::PH_HI);
        cmd.mul_cmb = (state_reg == dcm_pkg::ST_MUL) && (phase_reg == dcm_pkg::PH_CMB);
        cmd.sub     = (state_reg == dcm_pkg::ST_SUB);
        cmd.addv    = (state_reg == dcm_pkg::ST_ADDV);
        cmd.addp    = (state_reg == dcm_pkg::ST_ADDP);
        cmd.clamp   = (state_reg == dcm_pkg::ST_CLAMP) && !stat.out_busy;
    end

    assign in_stall = (state_reg != dcm_pkg::ST_IDLE);

endmodule

@@ rtl/dcm_dpath.sv @@
// Datapath of the DC motor Euler model: state registers, the shared
// 32-bit multiplier with its partial products, saturating adders and the
// output register. Driven by dcm_ctrl through dcm_pkg command structs.
module dcm_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [15:0]   current_command,
    input  dcm_pkg::coef_t       coef,
    input  dcm_pkg::dp_cmd_t     cmd,
    output dcm_pkg::dp_stat_t    stat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   encoder_position,
    output logic                 position_saturated
);

    localparam logic [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] INT64_MIN = {1'b1, {63{1'b0}}};

    logic [63:0]        v_reg, v_next;
    logic [63:0]        p_reg, p_next;
    logic [63:0]        torque_reg;
    logic [63:0]        t_reg;
    logic [63:0]        mres_reg;
    logic [63:0]        plo_reg;
    logic [63:0]        phi_reg;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        pos_reg;
    logic               sat_reg;

    logic signed [48:0] tq_prod;
    logic [63:0]        a_op;
    logic [31:0]        b_op;
    logic [63:0]        plo_w;
    logic [63:0]        phi_w;
    logic signed [95:0] prod;
    logic signed [95:0] shr;
    logic [63:0]        mres_w;
    logic [31:0]        pos_w;
    logic               sat_w;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? INT64_MIN : INT64_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? INT64_MIN : INT64_MAX;
        return s[63:0];
    endfunction

    // Command times gain is exact in 49 bits; the shift by 8 makes it Q32.32.
    assign tq_prod = $signed({{33{current_command[15]}}, current_command})
                   * $signed({17'b0, coef.torque_gain});

    always_comb
    begin
        case (cmd.op)
            dcm_pkg::MUL_FR:
            begin
                a_op = v_reg;
                b_op = coef.friction_coeff;
            end
            dcm_pkg::MUL_ACC:
            begin
                a_op = t_reg;
                b_op = coef.inverse_inertia;
            end
            dcm_pkg::MUL_DV:
            begin
                a_op = mres_reg;
                b_op = coef.substep_time;
            end
            dcm_pkg::MUL_DP:
            begin
                a_op = v_reg;
                b_op = coef.substep_time;
            end
            default:
            begin
                a_op = p_reg;
                b_op = coef.counts_per_radian;
            end
        endcase
    end

    // The 64 by 32 product is built from an unsigned low half and a signed
    // high half, one 32-bit multiply per cycle.
    assign plo_w = {32'b0, a_op[31:0]} * {32'b0, b_op};
    assign phi_w = $signed({{32{a_op[63]}}, a_op[63:32]}) * $signed({32'b0, b_op});
    assign prod  = $signed({phi_reg, 32'b0}) + $signed({32'b0, plo_reg});

    always_comb
    begin
        case (cmd.op)
            dcm_pkg::MUL_FR:  shr = prod >>> 24;
            dcm_pkg::MUL_ACC: shr = prod >>> 12;
            dcm_pkg::MUL_DV:  shr = prod >>> 32;
            dcm_pkg::MUL_DP:  shr = prod >>> 32;
            default:          shr = prod >>> 48;
        endcase
        if (shr[95:63] == {33{shr[95]}})
            mres_w = shr[63:0];
        else
            mres_w = shr[95] ? INT64_MIN : INT64_MAX;
    end

    always_comb
    begin
        if (!mres_reg[63] && (mres_reg[62:31] != '0))
        begin
            pos_w = {1'b0, {31{1'b1}}};
            sat_w = 1'b1;
        end
        else if (mres_reg[63] && (mres_reg[62:31] != '1))
        begin
            pos_w = {1'b1, {31{1'b0}}};
            sat_w = 1'b1;
        end
        else
        begin
            pos_w = mres_reg[31:0];
            sat_w = 1'b0;
        end
    end

    always_comb
    begin
        v_next         = v_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg;
        if (cmd.addv)
            v_next = sat_add(v_reg, mres_reg);
        if (cmd.addp)
            p_next = sat_add(p_reg, mres_reg);
        if (cmd.clamp)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg         <= v_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            torque_reg <= {{7{tq_prod[48]}}, tq_prod, 8'b0};
        if (cmd.mul_lo)
            plo_reg <= plo_w;
        if (cmd.mul_hi)
            phi_reg <= phi_w;
        if (cmd.mul_cmb)
            mres_reg <= mres_w;
        if (cmd.sub)
            t_reg <= sat_sub(torque_reg, mres_reg);
        if (cmd.clamp)
        begin
            pos_reg <= pos_w;
            sat_reg <= sat_w;
        end
    end

    assign stat.out_busy      = out_valid_reg && out_stall;
    assign out_valid          = out_valid_reg;
    assign encoder_position   = $signed(pos_reg);
    assign position_saturated = sat_reg;

endmodule
